FILE: design/plva_pkg.sv
// package: shared payload layouts and field widths of the voice allocator
`default_nettype none
package plva_pkg;

   localparam int ReqDataWidth = 32;
   localparam int RspDataWidth = 24;

   // request payload, lowest field in the lowest bits
   typedef struct packed {
      logic [15:0] sound_id;
      logic [7:0]  busy_mask;
      logic [7:0]  request_priority;
   } req_data_type;

   // response payload, lowest field in the lowest bits
   typedef struct packed {
      logic [2:0]  pad;
      logic [15:0] start_sound_id;
      logic        stolen;
      logic [2:0]  voice_index;
      logic        granted;
   } rsp_data_type;

endpackage
`default_nettype wire

FILE: design/priority_lru_voice_allocator.sv
// top level: priority lru voice allocator with recency and priority tables in ram
//
// usage: one request transaction on req_* yields exactly one response on rsp_*.
// req_tdata carries request_priority, busy_mask and sound_id; rsp_tdata carries
// granted, voice_index, stolen and start_sound_id. the recency list and the
// per-voice priorities live in two single-read, single-write rams with registered
// reads. a request walks the recency list once through a two-stage read
// pipeline (order ram, then priority ram), picks the first idle voice or else the
// least recently used voice of low enough priority, then moves it to the front
// with one ram write per shifted position and writes the new priority.
// one request is in flight at a time: a new request is taken only after the
// response of the last one has been loaded into the output register.
// reset: the list reads as voice p at place p and all priorities read as zero
// through per-entry valid flags; no clearing pass is needed. a finished response
// waits in the output register while rsp_tready is low, and a new request is
// already taken during that wait; the next response waits for the slot to free.
`default_nettype none
module priority_lru_voice_allocator
   import plva_pkg::*;
#(
   parameter int NUM_VOICES    = 8,
   parameter int PRIORITY_BITS = 8
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   // request_priority [7:0], busy_mask [15:8], sound_id [31:16]
   input  wire  [ReqDataWidth-1:0] req_tdata,
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   // granted [0], voice_index [3:1], stolen [4], start_sound_id [20:5], zero [23:21]
   output logic [RspDataWidth-1:0] rsp_tdata
);

   localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int PW = $clog2(NUM_VOICES + 1);
   localparam int PB = PRIORITY_BITS;
   localparam logic [PW-1:0] LastCnt = PW'(NUM_VOICES);
   localparam logic [VW-1:0] LastPos = VW'(NUM_VOICES - 1);

   localparam logic [2:0] StIdle   = 3'd0;
   localparam logic [2:0] StScan   = 3'd1;
   localparam logic [2:0] StDecide = 3'd2;
   localparam logic [2:0] StShift  = 3'd3;
   localparam logic [2:0] StCommit = 3'd4;
   localparam logic [2:0] StDone   = 3'd5;

   req_data_type req_in;
   rsp_data_type rsp_data_in, rsp_data_ff;

   logic [2:0]    state_ff, state_in;
   logic [PB-1:0] prio_ff, prio_in;
   logic [7:0]    mask_ff, mask_in;
   logic [15:0]   sid_ff, sid_in;
   logic [15:0]   req_prio_ext;
   logic [PW-1:0] rd_cnt_ff, rd_cnt_in;
   logic          s1_vld_ff, s1_vld_in;
   logic          s2_vld_ff, s2_vld_in;
   logic [VW-1:0] s2_pos_ff, s2_pos_in;
   logic [VW-1:0] s2_voice_ff, s2_voice_in;
   logic          idle_hit_ff, idle_hit_in;
   logic [VW-1:0] idle_pos_ff, idle_pos_in;
   logic [VW-1:0] idle_voice_ff, idle_voice_in;
   logic          steal_hit_ff, steal_hit_in;
   logic [VW-1:0] steal_pos_ff, steal_pos_in;
   logic [VW-1:0] steal_voice_ff, steal_voice_in;
   logic [VW-1:0] sel_voice_ff, sel_voice_in;
   logic          granted_ff, granted_in;
   logic          stolen_ff, stolen_in;
   logic [VW-1:0] sh_cnt_ff, sh_cnt_in;
   logic          sh_pend_ff, sh_pend_in;
   logic [VW-1:0] sh_wa_ff, sh_wa_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // recency list ram
   logic [VW-1:0]         order_mem [NUM_VOICES];
   logic [NUM_VOICES-1:0] order_vld_ff, order_vld_in;
   logic [VW-1:0]         order_rd_ff, order_ra_ff, order_raddr, order_rdat;
   logic                  order_rvld_ff;
   logic                  order_we;
   logic [VW-1:0]         order_wa, order_wd;

   // per-voice priority ram
   logic [PB-1:0]         prio_mem [NUM_VOICES];
   logic [NUM_VOICES-1:0] prio_vld_ff, prio_vld_in;
   logic [PB-1:0]         prio_rd_ff, prio_rdat;
   logic                  prio_rvld_ff;
   logic                  prio_we;

   logic [7:0]    s2_voice_ext, sel_voice_ext;
   logic          s2_idle;
   logic [VW-1:0] pick_pos, pick_voice;

   // unwritten entries read as their reset contents
   assign order_rdat = order_rvld_ff ? order_rd_ff : order_ra_ff;
   assign prio_rdat  = prio_rvld_ff ? prio_rd_ff : '0;

   assign req_in       = req_data_type'(req_tdata);
   assign req_prio_ext = 16'(req_in.request_priority);
   assign s2_voice_ext = 8'(s2_voice_ff);
   assign sel_voice_ext = 8'(sel_voice_ff);
   // voices without a mask bit count as busy
   assign s2_idle = (s2_voice_ext < 8'd8) && !mask_ff[s2_voice_ext[2:0]];
   assign pick_pos   = idle_hit_ff ? idle_pos_ff : steal_pos_ff;
   assign pick_voice = idle_hit_ff ? idle_voice_ff : steal_voice_ff;

   assign req_tready = (state_ff == StIdle);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in       = state_ff;
      prio_in        = prio_ff;
      mask_in        = mask_ff;
      sid_in         = sid_ff;
      rd_cnt_in      = rd_cnt_ff;
      s1_vld_in      = 1'b0;
      s2_vld_in      = s1_vld_ff;
      s2_pos_in      = order_ra_ff;
      s2_voice_in    = order_rdat;
      idle_hit_in    = idle_hit_ff;
      idle_pos_in    = idle_pos_ff;
      idle_voice_in  = idle_voice_ff;
      steal_hit_in   = steal_hit_ff;
      steal_pos_in   = steal_pos_ff;
      steal_voice_in = steal_voice_ff;
      sel_voice_in   = sel_voice_ff;
      granted_in     = granted_ff;
      stolen_in      = stolen_ff;
      sh_cnt_in      = sh_cnt_ff;
      sh_pend_in     = 1'b0;
      sh_wa_in       = sh_wa_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      order_raddr    = '0;
      order_we       = 1'b0;
      order_wa       = '0;
      order_wd       = '0;
      prio_we        = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         StIdle: begin
            if (req_tvalid) begin
               prio_in      = req_prio_ext[PB-1:0];
               mask_in      = req_in.busy_mask;
               sid_in       = req_in.sound_id;
               rd_cnt_in    = '0;
               idle_hit_in  = 1'b0;
               steal_hit_in = 1'b0;
               state_in     = StScan;
            end
         end
         StScan: begin
            if (rd_cnt_ff != LastCnt) begin
               order_raddr = rd_cnt_ff[VW-1:0];
               s1_vld_in   = 1'b1;
               rd_cnt_in   = rd_cnt_ff + 1'b1;
            end
            if (s2_vld_ff) begin
               if (s2_idle && !idle_hit_ff) begin
                  idle_hit_in   = 1'b1;
                  idle_pos_in   = s2_pos_ff;
                  idle_voice_in = s2_voice_ff;
               end
               // the last match in list order is the least recent one
               if (prio_rdat <= prio_ff) begin
                  steal_hit_in   = 1'b1;
                  steal_pos_in   = s2_pos_ff;
                  steal_voice_in = s2_voice_ff;
               end
               if (s2_pos_ff == LastPos) begin
                  state_in = StDecide;
               end
            end
         end
         StDecide: begin
            if (idle_hit_ff || steal_hit_ff) begin
               granted_in   = 1'b1;
               stolen_in    = !idle_hit_ff;
               sh_cnt_in    = pick_pos;
               sel_voice_in = pick_voice;
               state_in     = (pick_pos == '0) ? StCommit : StShift;
            end else begin
               granted_in = 1'b0;
               stolen_in  = 1'b0;
               state_in   = StDone;
            end
         end
         StShift: begin
            // read place i-1, write it to place i in the following cycle
            if (sh_cnt_ff != '0) begin
               order_raddr = sh_cnt_ff - 1'b1;
               sh_pend_in  = 1'b1;
               sh_wa_in    = sh_cnt_ff;
               sh_cnt_in   = sh_cnt_ff - 1'b1;
            end
            if (sh_pend_ff) begin
               order_we = 1'b1;
               order_wa = sh_wa_ff;
               order_wd = order_rdat;
               if (sh_cnt_ff == '0) begin
                  state_in = StCommit;
               end
            end
         end
         StCommit: begin
            order_we = 1'b1;
            order_wa = '0;
            order_wd = sel_voice_ff;
            prio_we  = 1'b1;
            state_in = StDone;
         end
         StDone: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.pad            = '0;
               rsp_data_in.granted        = granted_ff;
               rsp_data_in.voice_index    = granted_ff ? sel_voice_ext[2:0] : 3'd0;
               rsp_data_in.stolen         = stolen_ff;
               rsp_data_in.start_sound_id = granted_ff ? sid_ff : 16'd0;
               state_in                   = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase

      order_vld_in = order_vld_ff;
      if (order_we) begin
         order_vld_in[order_wa] = 1'b1;
      end
      prio_vld_in = prio_vld_ff;
      if (prio_we) begin
         prio_vld_in[sel_voice_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (order_we) begin
         order_mem[order_wa] <= order_wd;
      end
      order_rd_ff   <= order_mem[order_raddr];
      order_rvld_ff <= order_vld_ff[order_raddr];
      order_ra_ff   <= order_raddr;
      if (prio_we) begin
         prio_mem[sel_voice_ff] <= prio_ff;
      end
      prio_rd_ff   <= prio_mem[order_rdat];
      prio_rvld_ff <= prio_vld_ff[order_rdat];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         sh_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         order_vld_ff <= '0;
         prio_vld_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s2_vld_in;
         sh_pend_ff   <= sh_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         order_vld_ff <= order_vld_in;
         prio_vld_ff  <= prio_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff        <= prio_in;
      mask_ff        <= mask_in;
      sid_ff         <= sid_in;
      rd_cnt_ff      <= rd_cnt_in;
      s2_pos_ff      <= s2_pos_in;
      s2_voice_ff    <= s2_voice_in;
      idle_hit_ff    <= idle_hit_in;
      idle_pos_ff    <= idle_pos_in;
      idle_voice_ff  <= idle_voice_in;
      steal_hit_ff   <= steal_hit_in;
      steal_pos_ff   <= steal_pos_in;
      steal_voice_ff <= steal_voice_in;
      sel_voice_ff   <= sel_voice_in;
      granted_ff     <= granted_in;
      stolen_ff      <= stolen_in;
      sh_cnt_ff      <= sh_cnt_in;
      sh_wa_ff       <= sh_wa_in;
      rsp_data_ff    <= rsp_data_in;
   end

endmodule
`default_nettype wire

FILE: design/plva_checker.sv
// checker: port-level assertions for the voice allocator, bound to the top level
`default_nettype none
module plva_checker
   import plva_pkg::*;
(
   input wire                    clock,
   input wire                    reset,
   input wire                    req_tvalid,
   input wire                    req_tready,
   input wire [ReqDataWidth-1:0] req_tdata,
   input wire                    rsp_tvalid,
   input wire                    rsp_tready,
   input wire [RspDataWidth-1:0] rsp_tdata
);

   rsp_data_type rsp;
   req_data_type req;

   assign rsp = rsp_data_type'(rsp_tdata);
   assign req = req_data_type'(req_tdata);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_reset_state: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("block not idle after reset");

   // a dropped request reports all zeros
   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp.granted |->
         rsp.voice_index == 3'd0 && !rsp.stolen && rsp.start_sound_id == 16'd0)
      else $error("dropped request carries data");

   a_steal_granted: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.stolen |-> rsp.granted && rsp.pad == 3'd0)
      else $error("steal without grant");

   // one request in flight at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req.sound_id == req.sound_id) |=> !req_tready)
      else $error("second request taken while busy");

endmodule

bind priority_lru_voice_allocator plva_checker u_plva_checker (.*);
`default_nettype wire

FILE: test/testbench.sv
// testbench for the priority lru voice allocator: predictor, scoreboard and stream drivers
import plva_pkg::*;

class allocation_tracker;
   bit [2:0]     recency [8];
   bit [7:0]     voice_prio [8];
   rsp_data_type expected_grants [$];
   int           errors;

   function new();
      for (int p = 0; p < 8; p++) begin
         recency[p] = p[2:0];
         voice_prio[p] = '0;
      end
      errors = 0;
   endfunction

   // predict the allocation for one accepted request and update the voice tables
   function void note_request(req_data_type req);
      rsp_data_type grant;
      int           pos;
      bit           steal;
      bit [2:0]     voice;
      grant = '0;
      pos = -1;
      steal = 1'b0;
      for (int p = 0; p < 8; p++) begin
         if (pos < 0 && !req.busy_mask[recency[p]]) pos = p;
      end
      // all busy: take the least recently used voice we outrank or tie
      for (int p = 7; p >= 0; p--) begin
         if (pos < 0 && voice_prio[recency[p]] <= req.request_priority) begin
            pos = p;
            steal = 1'b1;
         end
      end
      if (pos >= 0) begin
         voice = recency[pos];
         voice_prio[voice] = req.request_priority;
         for (int p = pos; p > 0; p--) recency[p] = recency[p-1];
         recency[0] = voice;
         grant.granted = 1'b1;
         grant.voice_index = voice;
         grant.stolen = steal;
         grant.start_sound_id = req.sound_id;
      end
      expected_grants.push_back(grant);
   endfunction

   function void compare_field(string name, int unsigned exp_val, int unsigned act_val);
      if (exp_val != act_val) begin
         $error("%s mismatch: expected 'h%0h, actual 'h%0h", name, exp_val, act_val);
         errors++;
      end
   endfunction

   function void check_response(rsp_data_type act);
      rsp_data_type exp_grant;
      if (expected_grants.size() == 0) begin
         $error("response transaction with nothing expected: 'h%0h", act);
         errors++;
         return;
      end
      exp_grant = expected_grants.pop_front();
      compare_field("granted", 32'(exp_grant.granted), 32'(act.granted));
      compare_field("voice_index", 32'(exp_grant.voice_index), 32'(act.voice_index));
      compare_field("stolen", 32'(exp_grant.stolen), 32'(act.stolen));
      compare_field("start_sound_id", 32'(exp_grant.start_sound_id),
                    32'(act.start_sound_id));
      compare_field("pad", 32'(exp_grant.pad), 32'(act.pad));
   endfunction

   function int outstanding();
      return expected_grants.size();
   endfunction
endclass

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RandomPerPhase = 460;
   localparam int HoldCycles = 400;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RspDataWidth-1:0] rsp_tdata;

   allocation_tracker tracker;
   int idle_pct;
   int stall_pct;
   bit hold_request;
   int hold_left;
   int sender_idle [4] = '{0, 47, 0, 37};
   int receiver_stall [4] = '{0, 0, 47, 37};

   priority_lru_voice_allocator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial begin
      #1_000_000;
      $display("FAIL");
      $finish;
   end

   // offer one request transaction, idling first at the current rate
   task automatic send_request(input bit [7:0] prio, input bit [7:0] mask,
                               input bit [15:0] sid);
      req_data_type req;
      req.request_priority = prio;
      req.busy_mask = mask;
      req.sound_id = sid;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= req;
      do @(posedge clock); while (!req_tready);
      tracker.note_request(req);
   endtask

   task automatic send_random();
      bit [7:0] prio;
      bit [7:0] mask;
      int       pick;
      pick = $urandom_range(99);
      // mostly busy masks so the steal and drop paths get real exercise
      if (pick < 40) mask = 8'hFF;
      else if (pick < 70) mask = 8'hFF ^ (8'h01 << $urandom_range(7));
      else if (pick < 85) mask = 8'($urandom_range(255));
      else mask = 8'($urandom_range(255) & $urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 35) prio = 8'($urandom_range(7));
      else if (pick < 45) prio = 8'h00;
      else if (pick < 55) prio = 8'hFF;
      else prio = 8'($urandom_range(255));
      send_request(prio, mask, 16'($urandom_range(16'hFFFF)));
   endtask

   // response side: check each transaction, stall at random or hold off on request
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_response(rsp_data_type'(rsp_tdata));
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      tracker = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      idle_pct = 0;
      stall_pct = 0;
      hold_request = 1'b0;
      hold_left = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: idle pick, steals on a tie and on a win, drops, then front-most idle
      send_request(8'h00, 8'h00, 16'h0000);
      send_request(8'hFF, 8'hFF, 16'hFFFF);
      send_request(8'h00, 8'hFF, 16'hA5A5);
      for (int k = 0; k < 8; k++) send_request(8'hFF, 8'hFF, 16'(16'h5A5A + k));
      send_request(8'hFE, 8'hFF, 16'h1234);
      send_request(8'h00, 8'hFF, 16'hFFFF);
      send_request(8'hFF, 8'hFF, 16'h8001);
      send_request(8'h80, 8'h7F, 16'h0001);
      send_request(8'h01, 8'hFE, 16'h7FFE);
      send_request(8'h55, 8'h00, 16'h8000);
      send_request(8'hAA, 8'hF0, 16'h00FF);
      send_request(8'h00, 8'h0F, 16'hFF00);

      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = sender_idle[ph];
         stall_pct = receiver_stall[ph];
         // long receiver hold-off so the allocator backs up into its input
         if (ph == 0) hold_request = 1'b1;
         for (int n = 0; n < RandomPerPhase; n++) send_random();
      end
      req_tvalid <= 1'b0;

      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

FILE: sim.f
design/plva_pkg.sv
design/priority_lru_voice_allocator.sv
design/plva_checker.sv
test/testbench.sv
